### src/gbb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbb_pkg
// Shared constants, types and fixed-point factors of the gray box blur.
// ----------------------------------------------------------------------------
package gbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_CAP = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int ROW_W      = 11;
  localparam int RESET_DIM  = 512;
  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int ROW_SUM_W  = 10;
  localparam int SUM_W      = 12;

  // gray = floor((299 r + 587 g + 114 b) / 1000) as one scaled weighted sum
  localparam int GRAY_COEF_W = 28;
  localparam int GRAY_SHIFT  = 28;
  localparam int GRAY_PROD_W = PIX_W + GRAY_COEF_W + 2;
  localparam logic [GRAY_COEF_W-1:0] GRAY_C_RED   = 28'd80262364;
  localparam logic [GRAY_COEF_W-1:0] GRAY_C_GREEN = 28'd157571932;
  localparam logic [GRAY_COEF_W-1:0] GRAY_C_BLUE  = 28'd30601704;

  // floor(sum / 9) by reciprocal multiply
  localparam int DIV9_K_W   = 12;
  localparam int DIV9_SHIFT = 15;
  localparam int DIV9_PROD_W = SUM_W + DIV9_K_W;
  localparam logic [DIV9_K_W-1:0] DIV9_K = 12'd3641;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_BIT = 2;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic wrap_emit;
    logic cur_emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic last;
  } win_ctl_t;

endpackage
`default_nettype wire

### src/gbb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/gbb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbb_ctrl
// Configuration registers and raster counters; tags each word with its
// column and the window edges of the result it completes.
// ----------------------------------------------------------------------------
module gbb_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [gbb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [gbb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            accept,
  output logic [gbb_pkg::COL_W-1:0]       item_col,
  output logic                            item_live,
  output gbb_pkg::win_ctl_t               item_ctl
);
  import gbb_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] w_last;
  logic [DIM_W-1:0] col_ext;
  logic [DIM_W-1:0] x_full;
  logic [ROW_W:0]   y_ext;
  logic [ROW_W:0]   h_ext;
  logic             x_zero;
  logic             cfg_write;
  cfg_reg_t         reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = cfg_reg_t'(paddr[CFG_IDX_BIT]);

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = height_r;
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(HEIGHT_CAP)) begin
      h_eff = DIM_W'(HEIGHT_CAP);
    end
    w_last  = w_eff - DIM_W'(1);
    col_ext = {{(DIM_W-COL_W){1'b0}}, col_r};
    x_full  = (col_ext > w_last) ? w_last : col_ext;
    x_zero  = (x_full == '0);
    y_ext   = {1'b0, row_r};
    h_ext   = {1'b0, h_eff};

    item_col  = x_full[COL_W-1:0];
    item_live = (y_ext < h_ext);

    item_ctl.wrap_emit = x_zero && (y_ext >= (ROW_W+1)'(2))
                         && (y_ext < h_ext + (ROW_W+1)'(2));
    item_ctl.cur_emit  = !x_zero && (y_ext >= (ROW_W+1)'(1))
                         && (y_ext < h_ext + (ROW_W+1)'(1));
    item_ctl.top_ok    = x_zero ? (y_ext >= (ROW_W+1)'(3)) : (y_ext >= (ROW_W+1)'(2));
    item_ctl.bot_ok    = x_zero ? (y_ext < h_ext + (ROW_W+1)'(1)) : (y_ext < h_ext);
    item_ctl.left_ok   = x_zero ? (w_eff >= DIM_W'(2)) : (x_full >= DIM_W'(2));
    item_ctl.last      = item_ctl.wrap_emit && (y_ext == h_ext + (ROW_W+1)'(1));

    if (item_ctl.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (x_full == w_last) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = x_full[COL_W-1:0] + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata[DIM_W-1:0] = width_r;
      REG_IMAGE_HEIGHT: prdata[DIM_W-1:0] = height_r;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(RESET_DIM);
      height_r <= DIM_W'(RESET_DIM);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default:          width_r  <= width_r;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

### src/gbb_line.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbb_line
// Input register, gray conversion and the two-row line store with a
// write-to-read bypass for back-to-back words at the same column.
// ----------------------------------------------------------------------------
module gbb_line (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      accept,
  input  gbb_pkg::pix_t             in_red,
  input  gbb_pkg::pix_t             in_green,
  input  gbb_pkg::pix_t             in_blue,
  input  logic                      in_pad,
  input  logic [gbb_pkg::COL_W-1:0] item_col,
  input  logic                      item_live,
  input  gbb_pkg::win_ctl_t         item_ctl,
  output logic                      pix_valid,
  output gbb_pkg::pix_t             pix_top,
  output gbb_pkg::pix_t             pix_mid,
  output gbb_pkg::pix_t             pix_gray,
  output gbb_pkg::win_ctl_t         pix_ctl
);
  import gbb_pkg::*;

  logic                   s1_valid_r;
  pix_t                   s1_red_r;
  pix_t                   s1_green_r;
  pix_t                   s1_blue_r;
  logic                   s1_live_r;
  logic [COL_W-1:0]       s1_col_r;
  win_ctl_t               s1_ctl_r;
  logic                   fwd_valid_r;
  logic [LINE_W-1:0]      fwd_data_r;
  logic [LINE_W-1:0]      ram_rdata;
  logic [LINE_W-1:0]      line_word;
  logic [GRAY_PROD_W-1:0] gray_acc;
  pix_t                   gray;
  pix_t                   mid;
  pix_t                   top;
  logic                   s2_valid_r;
  pix_t                   s2_top_r;
  pix_t                   s2_mid_r;
  pix_t                   s2_gray_r;
  win_ctl_t               s2_ctl_r;

  gbb_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (en && s1_valid_r),
    .waddr (s1_col_r),
    .wdata ({mid, gray}),
    .re    (en),
    .raddr (item_col),
    .rdata (ram_rdata)
  );

  always_comb begin
    line_word = fwd_valid_r ? fwd_data_r : ram_rdata;
    top       = line_word[LINE_W-1:PIX_W];
    mid       = line_word[PIX_W-1:0];
    gray_acc  = GRAY_PROD_W'(s1_red_r)   * GRAY_PROD_W'(GRAY_C_RED)
              + GRAY_PROD_W'(s1_green_r) * GRAY_PROD_W'(GRAY_C_GREEN)
              + GRAY_PROD_W'(s1_blue_r)  * GRAY_PROD_W'(GRAY_C_BLUE);
    gray      = s1_live_r ? gray_acc[GRAY_SHIFT +: PIX_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      fwd_valid_r <= accept && s1_valid_r && (item_col == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_live_r  <= item_live && !in_pad;
      s1_col_r   <= item_col;
      s1_ctl_r   <= item_ctl;
      fwd_data_r <= {mid, gray};
      s2_top_r   <= top;
      s2_mid_r   <= mid;
      s2_gray_r  <= gray;
      s2_ctl_r   <= s1_ctl_r;
    end
  end

  assign pix_valid = s2_valid_r;
  assign pix_top   = s2_top_r;
  assign pix_mid   = s2_mid_r;
  assign pix_gray  = s2_gray_r;
  assign pix_ctl   = s2_ctl_r;

endmodule
`default_nettype wire

### src/gbb_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbb_window
// Two stored window columns plus the incoming column; forms the masked
// 3x3 neighborhood sum.
// ----------------------------------------------------------------------------
module gbb_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      pix_valid,
  input  gbb_pkg::pix_t             pix_top,
  input  gbb_pkg::pix_t             pix_mid,
  input  gbb_pkg::pix_t             pix_gray,
  input  gbb_pkg::win_ctl_t         pix_ctl,
  output logic                      sum_valid,
  output logic [gbb_pkg::SUM_W-1:0] sum,
  output logic                      sum_last
);
  import gbb_pkg::*;

  pix_t                 prev_col_r [3];
  pix_t                 last_col_r [3];
  pix_t                 new_col    [3];
  logic [ROW_SUM_W-1:0] row_sum    [3];
  logic [SUM_W-1:0]     sum_nxt;
  logic                 sum_valid_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 last_r;

  always_comb begin
    new_col[0] = pix_top;
    new_col[1] = pix_mid;
    new_col[2] = pix_gray;
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = (pix_ctl.left_ok  ? ROW_SUM_W'(prev_col_r[r]) : '0)
                 + ROW_SUM_W'(last_col_r[r])
                 + (pix_ctl.cur_emit ? ROW_SUM_W'(new_col[r])    : '0);
    end
    sum_nxt = (pix_ctl.top_ok ? SUM_W'(row_sum[0]) : '0)
            + SUM_W'(row_sum[1])
            + (pix_ctl.bot_ok ? SUM_W'(row_sum[2]) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (en) begin
      sum_valid_r <= pix_valid && (pix_ctl.wrap_emit || pix_ctl.cur_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      last_r <= pix_ctl.last;
      if (pix_valid) begin
        for (int r = 0; r < 3; r++) begin
          prev_col_r[r] <= last_col_r[r];
          last_col_r[r] <= new_col[r];
        end
      end
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;
  assign sum_last  = last_r;

endmodule
`default_nettype wire

### src/gbb_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbb_out
// Divide by nine, output register and one-word skid buffer; the skid
// state sets the pipeline enable.
// ----------------------------------------------------------------------------
module gbb_out (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      sum_valid,
  input  logic [gbb_pkg::SUM_W-1:0] sum,
  input  logic                      sum_last,
  input  logic                      out_stall,
  output logic                      out_valid,
  output gbb_pkg::pix_t             out_blurred_gray,
  output logic                      out_last_pixel,
  output logic                      en
);
  import gbb_pkg::*;

  logic [DIV9_PROD_W-1:0] res_prod;
  pix_t                   res_gray;
  logic                   res_valid;
  logic                   out_take;
  logic                   out_valid_r;
  pix_t                   out_gray_r;
  logic                   out_last_r;
  logic                   skid_valid_r;
  pix_t                   skid_gray_r;
  logic                   skid_last_r;

  assign res_prod  = DIV9_PROD_W'(sum) * DIV9_PROD_W'(DIV9_K);
  assign res_gray  = res_prod[DIV9_SHIFT +: PIX_W];
  assign en        = !skid_valid_r;
  assign res_valid = en && sum_valid;
  assign out_take  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_gray_r <= skid_gray_r;
        out_last_r <= skid_last_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_gray_r <= res_gray;
        skid_last_r <= sum_last;
      end else begin
        out_gray_r <= res_gray;
        out_last_r <= sum_last;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_blurred_gray = out_gray_r;
  assign out_last_pixel   = out_last_r;

endmodule
`default_nettype wire

### src/gray_box_blur_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gray_box_blur_3x3
// RGB to gray conversion followed by a zero-padded 3x3 box mean filter over
// a raster stream, with pad words to flush the last row.
// ----------------------------------------------------------------------------
//   channel   direction   handshake             payload
//   in_       input       in_valid / in_stall   in_red, in_green, in_blue, in_pad
//   out_      output      out_valid / out_stall out_blurred_gray, out_last_pixel
//   cfg       apb         psel / penable        image_width @0, image_height @4
//
// one word per cycle sustained while in_stall is low; a result passes the stage-one,
// stage-two and sum registers into the output register once the word releasing it is
// accepted, which for the last column of a row is the first word of the row after next
// the line store memory needs no clearing pass, words are taken right after reset
// a full skid buffer stalls the whole pipeline, so in_stall rises in the cycle
// after the second result is held back by out_stall
// ----------------------------------------------------------------------------
module gray_box_blur_3x3 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gbb_pkg::pix_t                  in_red,
  input  gbb_pkg::pix_t                  in_green,
  input  gbb_pkg::pix_t                  in_blue,
  input  logic                           in_pad,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gbb_pkg::pix_t                  out_blurred_gray,
  output logic                           out_last_pixel,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gbb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gbb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gbb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import gbb_pkg::*;

  logic             en;
  logic             accept;
  logic [COL_W-1:0] item_col;
  logic             item_live;
  win_ctl_t         item_ctl;
  logic             pix_valid;
  pix_t             pix_top;
  pix_t             pix_mid;
  pix_t             pix_gray;
  win_ctl_t         pix_ctl;
  logic             sum_valid;
  logic [SUM_W-1:0] sum;
  logic             sum_last;

  assign in_stall = !en;
  assign accept   = in_valid && en;

  gbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .accept    (accept),
    .item_col  (item_col),
    .item_live (item_live),
    .item_ctl  (item_ctl)
  );

  gbb_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .accept    (accept),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_pad    (in_pad),
    .item_col  (item_col),
    .item_live (item_live),
    .item_ctl  (item_ctl),
    .pix_valid (pix_valid),
    .pix_top   (pix_top),
    .pix_mid   (pix_mid),
    .pix_gray  (pix_gray),
    .pix_ctl   (pix_ctl)
  );

  gbb_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .pix_valid (pix_valid),
    .pix_top   (pix_top),
    .pix_mid   (pix_mid),
    .pix_gray  (pix_gray),
    .pix_ctl   (pix_ctl),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_last  (sum_last)
  );

  gbb_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .sum_valid        (sum_valid),
    .sum              (sum),
    .sum_last         (sum_last),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_blurred_gray (out_blurred_gray),
    .out_last_pixel   (out_last_pixel),
    .en               (en)
  );

endmodule
`default_nettype wire
